/* src/csa_pkg.sv */
package csa_pkg;

	// field widths
	localparam int ACT_W   = 3;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;

	typedef logic [ACT_W-1:0]   act_t;
	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [HOUR_W-1:0]  hour_t;
	typedef logic [MIN_W-1:0]   min_t;

	// action codes
	localparam act_t ACT_ADD_MIN  = 3'd0;
	localparam act_t ACT_ADD_5MIN = 3'd1;
	localparam act_t ACT_ADD_HOUR = 3'd2;
	localparam act_t ACT_SUB_HOUR = 3'd3;
	localparam act_t ACT_ADD_DAY  = 3'd4;
	localparam act_t ACT_SUB_DAY  = 3'd5;

	localparam year_t  YEAR_MAX  = 14'd9999;
	localparam month_t MON_JAN   = 4'd1;
	localparam month_t MON_FEB   = 4'd2;
	localparam month_t MON_DEC   = 4'd12;
	localparam day_t   DAY_LONG  = 5'd31;
	localparam hour_t  HOUR_MAX  = 5'd23;
	localparam min_t   MIN_MAX   = 6'd59;
	localparam min_t   MIN_STEP5 = 6'd5;

	// year / 100 as (year * 5243) >> 19, exact over the 14-bit range
	localparam int DIV100_MUL   = 5243;
	localparam int MUL_W        = 13;
	localparam int DIV100_SHIFT = 19;
	localparam int PROD_W       = YEAR_W + MUL_W;
	localparam int QUOT_W       = PROD_W - DIV100_SHIFT;
	localparam int CENT_W       = YEAR_W + 1;
	localparam int CENTURY      = 100;

	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [QUOT_W-1:0] quot_t;
	typedef logic [CENT_W-1:0] cent_t;

	typedef struct packed {
		act_t   action;
		year_t  year;
		month_t month;
		day_t   day;
		hour_t  hour;
		min_t   minute;
	} item_t;

	typedef struct packed {
		year_t  year;
		month_t month;
		day_t   day;
		hour_t  hour;
		min_t   minute;
	} stamp_t;

	// check results handed from the check stage to the step stage
	typedef struct packed {
		logic leap;
		logic bad;
		day_t mlen;
	} check_t;

	function automatic day_t month_len(input month_t month, input logic leap);
		day_t len;
		case (month) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			MON_FEB:                                     len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

/* src/csa_check.sv */
// leap year, month length and range check for one item
module csa_check (
	input  csa_pkg::item_t  item,
	input  csa_pkg::prod_t  prod,   // item.year * DIV100_MUL, registered
	output csa_pkg::check_t chk
);

	csa_pkg::quot_t quot;
	csa_pkg::cent_t cent;
	logic           cent_hit;
	logic           leap;
	csa_pkg::day_t  mlen;

	assign quot     = prod[csa_pkg::DIV100_SHIFT +: csa_pkg::QUOT_W];
	assign cent     = csa_pkg::cent_t'(quot) * csa_pkg::cent_t'(csa_pkg::CENTURY);
	assign cent_hit = (csa_pkg::cent_t'(item.year) == cent);
	assign leap     = ((item.year[1:0] == 2'b00) && !cent_hit) ||
	                  (cent_hit && (quot[1:0] == 2'b00));
	assign mlen     = csa_pkg::month_len(item.month, leap);

	assign chk.leap = leap;
	assign chk.mlen = mlen;
	assign chk.bad  = (item.action > csa_pkg::ACT_SUB_DAY) ||
	                  (item.year > csa_pkg::YEAR_MAX) ||
	                  (item.month < csa_pkg::MON_JAN) ||
	                  (item.month > csa_pkg::MON_DEC) ||
	                  (item.hour > csa_pkg::HOUR_MAX) ||
	                  (item.minute > csa_pkg::MIN_MAX) ||
	                  (item.day == '0) ||
	                  (item.day > mlen);

endmodule

/* src/csa_step.sv */
// applies the action with minute -> hour -> day -> month -> year carries
module csa_step (
	input  csa_pkg::item_t  item,
	input  csa_pkg::check_t chk,
	output csa_pkg::stamp_t res
);

	logic hr_up, hr_dn, d_up, d_dn;

	always_comb begin
		res.year   = item.year;
		res.month  = item.month;
		res.day    = item.day;
		res.hour   = item.hour;
		res.minute = item.minute;
		hr_up = 1'b0;
		hr_dn = 1'b0;
		d_up  = 1'b0;
		d_dn  = 1'b0;

		if (!chk.bad) begin
			case (item.action)
				csa_pkg::ACT_ADD_MIN: begin
					if (item.minute == csa_pkg::MIN_MAX) begin
						res.minute = '0;
						hr_up      = 1'b1;
					end else begin
						res.minute = item.minute + 1'b1;
					end
				end
				csa_pkg::ACT_ADD_5MIN: begin
					// five single steps wrap at most once
					if (item.minute > csa_pkg::MIN_MAX - csa_pkg::MIN_STEP5) begin
						res.minute = item.minute + csa_pkg::MIN_STEP5 - csa_pkg::MIN_MAX - 1'b1;
						hr_up      = 1'b1;
					end else begin
						res.minute = item.minute + csa_pkg::MIN_STEP5;
					end
				end
				csa_pkg::ACT_ADD_HOUR: hr_up = 1'b1;
				csa_pkg::ACT_SUB_HOUR: hr_dn = 1'b1;
				csa_pkg::ACT_ADD_DAY:  d_up  = 1'b1;
				default:               d_dn  = 1'b1;
			endcase
		end

		if (hr_up) begin
			if (item.hour == csa_pkg::HOUR_MAX) begin
				res.hour = '0;
				d_up     = 1'b1;
			end else begin
				res.hour = item.hour + 1'b1;
			end
		end
		if (hr_dn) begin
			if (item.hour == '0) begin
				res.hour = csa_pkg::HOUR_MAX;
				d_dn     = 1'b1;
			end else begin
				res.hour = item.hour - 1'b1;
			end
		end

		// valid input guarantees day <= mlen, so the carry is an equality
		if (d_up) begin
			if (item.day == chk.mlen) begin
				res.day = csa_pkg::day_t'(1);
				if (item.month == csa_pkg::MON_DEC) begin
					res.month = csa_pkg::MON_JAN;
					res.year  = (item.year == csa_pkg::YEAR_MAX) ? '0 : item.year + 1'b1;
				end else begin
					res.month = item.month + 1'b1;
				end
			end else begin
				res.day = item.day + 1'b1;
			end
		end
		// previous month is December or in the same year: leap of this year holds
		if (d_dn) begin
			if (item.day > csa_pkg::day_t'(1)) begin
				res.day = item.day - 1'b1;
			end else if (item.month == csa_pkg::MON_JAN) begin
				res.month = csa_pkg::MON_DEC;
				res.year  = (item.year == '0) ? csa_pkg::YEAR_MAX : item.year - 1'b1;
				res.day   = csa_pkg::DAY_LONG;
			end else begin
				res.month = item.month - 1'b1;
				res.day   = csa_pkg::month_len(csa_pkg::month_t'(item.month - 1'b1), chk.leap);
			end
		end
	end

endmodule

/* src/calendar_step_adjust_core.sv */
// Gregorian date/time step adjuster.
// Input stream (s_*): one beat carries an action code and a date and time
// (year, month, day, hour, minute). Actions: add one minute, add five
// minutes, add one hour, subtract one hour, add one day, subtract one day.
// Output stream (m_*): one beat per input beat, in order, with the adjusted
// date and time in m_tdata and the invalid flag in m_tuser. An out-of-range
// action, date or time sets invalid and returns the input fields unchanged.
// Pipeline: three register stages.
//   s1: input beat and year * 5243 product (divide-by-100 reciprocal)
//   s2: leap year, month length, range check
//   s3: carry chain minute -> hour -> day -> month -> year; output register
// A beat passes s1, s2 and s3 in turn, and m_tvalid is the s3 valid bit.
// Throughput is one beat per cycle; every stage takes a new beat whenever it
// is empty or the stage after it moves on.
// When m_tready is low the stages fill up, and s_tready drops once all three
// hold a beat; nothing is dropped or repeated.
// Reset (arst_n low) clears all stage valid bits; payload is not reset.
module calendar_step_adjust_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // action[2:0], in_year[16:3], in_month[20:17],
	                               // in_day[25:21], in_hour[30:26], in_minute[36:31]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_year[13:0], out_month[17:14], out_day[22:18],
	                               // out_hour[27:23], out_minute[33:28]
	output logic        m_tuser    // invalid
);

	csa_pkg::item_t  in_item;

	logic            vld_s1, vld_s2, vld_s3;
	logic            rdy_s1, rdy_s2, rdy_s3;

	csa_pkg::item_t  item_s1, item_s2;
	csa_pkg::prod_t  prod_s1;
	csa_pkg::check_t chk, chk_s2;
	csa_pkg::stamp_t res, res_s3;
	logic            bad_s3;

	// unpack the input beat
	assign in_item.action = s_tdata[2:0];
	assign in_item.year   = s_tdata[16:3];
	assign in_item.month  = s_tdata[20:17];
	assign in_item.day    = s_tdata[25:21];
	assign in_item.hour   = s_tdata[30:26];
	assign in_item.minute = s_tdata[36:31];

	// a stage takes a beat when it is empty or its beat moves on
	assign rdy_s3   = !vld_s3 || m_tready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: capture and multiply by the reciprocal of 100
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			item_s1 <= in_item;
			prod_s1 <= csa_pkg::prod_t'(in_item.year) *
			           csa_pkg::prod_t'(csa_pkg::DIV100_MUL);
		end
	end

	// stage 2: leap year and range check
	csa_check u_check (
		.item (item_s1),
		.prod (prod_s1),
		.chk  (chk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			item_s2 <= item_s1;
			chk_s2  <= chk;
		end
	end

	// stage 3: apply the action, hold the result for the output
	csa_step u_step (
		.item (item_s2),
		.chk  (chk_s2),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			res_s3 <= res;
			bad_s3 <= chk_s2.bad;
		end
	end

	// pack the output beat
	assign m_tvalid = vld_s3;
	assign m_tdata  = {6'b0, res_s3.minute, res_s3.hour, res_s3.day,
	                   res_s3.month, res_s3.year};
	assign m_tuser  = bad_s3;

endmodule

/* bench/tb_calendar_step_adjust_core.sv */
module tb_calendar_step_adjust_core;
	timeunit 1ns;
	timeprecision 1ps;

	// codes outside the legal action range, used to provoke the invalid flag
	localparam csa_pkg::act_t ACT_BAD_LO = 3'd6;
	localparam csa_pkg::act_t ACT_BAD_HI = 3'd7;

	localparam int N_DIR          = 25;
	localparam int N_PER_PHASE    = 184;  // three random phases, ~550 beats total
	localparam int HOLD_CYCLES    = 64;   // long m_tready hold-off, fills the pipe
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 8;    // pipe is 3 deep

	// one expected output beat: adjusted stamp plus invalid flag
	typedef struct packed {
		csa_pkg::stamp_t t;
		logic            bad;
	} outcome_t;

	// directed row: input fields, and a hand-written answer where typed is set
	typedef struct packed {
		csa_pkg::act_t act;
		int            y, mo, d, h, mi;
		bit            typed;
		int            ey, emo, ed, eh, emi;
		bit            ebad;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	outcome_t pending_dates [$];
	int       fail_count    = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       holds_asked   = 0;
	int       holds_granted = 0;
	int       stall_left    = 0;

	calendar_step_adjust_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Directed beats. Typed answers cover the year wrap both ways, the year-0
	// leap rule, century leap rules and every kind of rejected input; the
	// remaining rows go through the predictor.
	dir_row_t dir_rows [N_DIR] = '{
		// up across the year 9999 boundary
		'{csa_pkg::ACT_ADD_MIN,  9999, 12, 31, 23, 59, 1'b1,    0,  1,  1,  0,  0, 1'b0},
		'{csa_pkg::ACT_ADD_5MIN, 9999, 12, 31, 23, 58, 1'b1,    0,  1,  1,  0,  3, 1'b0},
		'{csa_pkg::ACT_ADD_HOUR, 9999, 12, 31, 23,  0, 1'b1,    0,  1,  1,  0,  0, 1'b0},
		'{csa_pkg::ACT_ADD_DAY,  9999, 12, 31,  5,  6, 1'b1,    0,  1,  1,  5,  6, 1'b0},
		// down across year 0, which is a leap year
		'{csa_pkg::ACT_SUB_DAY,     0,  1,  1,  0,  0, 1'b1, 9999, 12, 31,  0,  0, 1'b0},
		'{csa_pkg::ACT_SUB_HOUR,    0,  1,  1,  0,  0, 1'b1, 9999, 12, 31, 23,  0, 1'b0},
		'{csa_pkg::ACT_SUB_DAY,     0,  3,  1, 12, 30, 1'b1,    0,  2, 29, 12, 30, 1'b0},
		// century rules: 1900 is not leap, 2000 is
		'{csa_pkg::ACT_ADD_DAY,  1900,  2, 28,  8, 15, 1'b1, 1900,  3,  1,  8, 15, 1'b0},
		'{csa_pkg::ACT_ADD_DAY,  2000,  2, 28,  8, 15, 1'b1, 2000,  2, 29,  8, 15, 1'b0},
		'{csa_pkg::ACT_SUB_DAY,  2100,  3,  1,  0,  0, 1'b0,    0,  0,  0,  0,  0, 1'b0},
		'{csa_pkg::ACT_ADD_HOUR, 2024,  2, 29, 23, 45, 1'b0,    0,  0,  0,  0,  0, 1'b0},
		'{csa_pkg::ACT_SUB_HOUR, 2023,  5,  1,  0, 59, 1'b0,    0,  0,  0,  0,  0, 1'b0},
		'{csa_pkg::ACT_ADD_MIN,  2023,  6, 15, 10, 20, 1'b0,    0,  0,  0,  0,  0, 1'b0},
		'{csa_pkg::ACT_ADD_5MIN, 2023,  1, 31, 23, 56, 1'b0,    0,  0,  0,  0,  0, 1'b0},
		// rejected beats pass through unchanged
		'{ACT_BAD_HI,           16383, 15, 31, 31, 63, 1'b1, 16383, 15, 31, 31, 63, 1'b1},
		'{ACT_BAD_LO,            2023,  6, 15, 10, 20, 1'b1, 2023,  6, 15, 10, 20, 1'b1},
		'{csa_pkg::ACT_ADD_MIN, 10000,  1,  1,  0,  0, 1'b1, 10000, 1,  1,  0,  0, 1'b1},
		'{csa_pkg::ACT_ADD_MIN,  2023,  0,  1,  0,  0, 1'b1, 2023,  0,  1,  0,  0, 1'b1},
		'{csa_pkg::ACT_ADD_DAY,  2023, 13,  1,  0,  0, 1'b1, 2023, 13,  1,  0,  0, 1'b1},
		'{csa_pkg::ACT_SUB_DAY,  2023,  3,  0,  0,  0, 1'b1, 2023,  3,  0,  0,  0, 1'b1},
		'{csa_pkg::ACT_ADD_DAY,  2023,  2, 29,  0,  0, 1'b1, 2023,  2, 29,  0,  0, 1'b1},
		'{csa_pkg::ACT_ADD_DAY,  2023,  4, 31,  0,  0, 1'b1, 2023,  4, 31,  0,  0, 1'b1},
		'{csa_pkg::ACT_ADD_HOUR, 2023,  4, 30, 24,  0, 1'b1, 2023,  4, 30, 24,  0, 1'b1},
		'{csa_pkg::ACT_ADD_MIN,  2023,  4, 30,  0, 60, 1'b1, 2023,  4, 30,  0, 60, 1'b1},
		'{csa_pkg::ACT_ADD_MIN,     0,  0,  0,  0,  0, 1'b1,    0,  0,  0,  0,  0, 1'b1}
	};

	// Gregorian month length; 0 for a month outside 1..12
	function automatic int days_in(input int yr, input int mon);
		if (mon < 1 || mon > 12)
			return 0;
		case (mon)
			4, 6, 9, 11: return 30;
			2: return ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 29 : 28;
			default: return 31;
		endcase
	endfunction

	// Predicts one output beat. Carries go minute -> hour -> day -> month -> year.
	// Five minutes from a legal minute carry at most once into the hour, so a
	// single add of five matches five one-minute steps.
	function automatic outcome_t adjust_date(input csa_pkg::item_t it);
		int       y, mo, d, h, mi;
		bit       h_up, h_dn, d_up, d_dn;
		outcome_t res;
		y  = it.year;
		mo = it.month;
		d  = it.day;
		h  = it.hour;
		mi = it.minute;
		h_up = 0;
		h_dn = 0;
		d_up = 0;
		d_dn = 0;
		res.bad = it.action > csa_pkg::ACT_SUB_DAY || y > csa_pkg::YEAR_MAX ||
		          mo < 1 || mo > 12 || d < 1 || d > days_in(y, mo) ||
		          h > csa_pkg::HOUR_MAX || mi > csa_pkg::MIN_MAX;
		if (!res.bad) begin
			case (it.action)
				csa_pkg::ACT_ADD_MIN:  mi += 1;
				csa_pkg::ACT_ADD_5MIN: mi += csa_pkg::MIN_STEP5;
				csa_pkg::ACT_ADD_HOUR: h_up = 1;
				csa_pkg::ACT_SUB_HOUR: h_dn = 1;
				csa_pkg::ACT_ADD_DAY:  d_up = 1;
				csa_pkg::ACT_SUB_DAY:  d_dn = 1;
				default: ;
			endcase
			if (mi > csa_pkg::MIN_MAX) begin
				mi -= 60;
				h_up = 1;
			end
			if (h_up) begin
				if (h == csa_pkg::HOUR_MAX) begin
					h = 0;
					d_up = 1;
				end else
					h++;
			end
			if (h_dn) begin
				if (h == 0) begin
					h = csa_pkg::HOUR_MAX;
					d_dn = 1;
				end else
					h--;
			end
			if (d_up) begin
				if (d == days_in(y, mo)) begin
					d = 1;
					if (mo == 12) begin
						mo = 1;
						y = (y == csa_pkg::YEAR_MAX) ? 0 : y + 1;
					end else
						mo++;
				end else
					d++;
			end
			if (d_dn) begin
				if (d > 1)
					d--;
				else begin
					if (mo == 1) begin
						mo = 12;
						y = (y == 0) ? csa_pkg::YEAR_MAX : y - 1;
					end else
						mo--;
					d = days_in(y, mo);
				end
			end
		end
		res.t.year   = csa_pkg::year_t'(y);
		res.t.month  = csa_pkg::month_t'(mo);
		res.t.day    = csa_pkg::day_t'(d);
		res.t.hour   = csa_pkg::hour_t'(h);
		res.t.minute = csa_pkg::min_t'(mi);
		return res;
	endfunction

	// Random beat. Mostly legal dates leaning on month, day, hour and minute
	// edges and on century / leap years; about a fifth are corrupted.
	function automatic csa_pkg::item_t make_date();
		csa_pkg::item_t it;
		int             len;
		it.action = csa_pkg::act_t'($urandom_range(csa_pkg::ACT_SUB_DAY));
		case ($urandom_range(4))
			0: it.year = 14'd0;
			1: it.year = csa_pkg::YEAR_MAX;
			2: it.year = csa_pkg::year_t'($urandom_range(99) * 100);
			3: it.year = csa_pkg::year_t'($urandom_range(2499) * 4);
			default: it.year = csa_pkg::year_t'($urandom_range(csa_pkg::YEAR_MAX));
		endcase
		it.month = csa_pkg::month_t'($urandom_range(12, 1));
		len = days_in(it.year, it.month);
		case ($urandom_range(3))
			0: it.day = csa_pkg::day_t'(len);
			1: it.day = 5'd1;
			2: it.day = csa_pkg::day_t'(len - 1);
			default: it.day = csa_pkg::day_t'($urandom_range(len, 1));
		endcase
		case ($urandom_range(3))
			0: it.hour = csa_pkg::HOUR_MAX;
			1: it.hour = 5'd0;
			default: it.hour = csa_pkg::hour_t'($urandom_range(csa_pkg::HOUR_MAX));
		endcase
		case ($urandom_range(3))
			0: it.minute = csa_pkg::MIN_MAX;
			1: it.minute = csa_pkg::min_t'($urandom_range(csa_pkg::MIN_MAX, 55));
			2: it.minute = 6'd0;
			default: it.minute = csa_pkg::min_t'($urandom_range(csa_pkg::MIN_MAX));
		endcase
		if ($urandom_range(99) < 20) begin
			case ($urandom_range(2))
				0: begin
					// raw noise over the full field widths
					it.action = csa_pkg::act_t'($urandom);
					it.year   = csa_pkg::year_t'($urandom);
					it.month  = csa_pkg::month_t'($urandom);
					it.day    = csa_pkg::day_t'($urandom);
					it.hour   = csa_pkg::hour_t'($urandom);
					it.minute = csa_pkg::min_t'($urandom);
				end
				1: it.day = csa_pkg::day_t'(len + 1);  // one day past month end
				default: it.action = csa_pkg::act_t'($urandom_range(ACT_BAD_HI, ACT_BAD_LO));
			endcase
		end
		return it;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Offers one beat, with random idle cycles ahead of it. Exactly one
	// nonblocking write to s_tvalid per edge; the expectation is queued once
	// the beat is taken.
	task automatic offer_date(input csa_pkg::item_t it, input outcome_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, it.minute, it.hour, it.day, it.month, it.year, it.action};
		do
			@(posedge clk);
		while (!s_tready);
		pending_dates.push_back(want);
	endtask

	// Receiver: random back-pressure, plus a long hold-off on request that is
	// counted down here so the sender keeps pushing into a stalled pipe.
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (holds_granted != holds_asked) begin
			holds_granted <= holds_granted + 1;
			stall_left    <= HOLD_CYCLES - 1;
			m_tready      <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Output side: every accepted beat is matched against the oldest expectation.
	always @(posedge clk) begin : watch_out
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.t.year   = m_tdata[13:0];
			got.t.month  = m_tdata[17:14];
			got.t.day    = m_tdata[22:18];
			got.t.hour   = m_tdata[27:23];
			got.t.minute = m_tdata[33:28];
			got.bad      = m_tuser;
			if (pending_dates.size() == 0)
				flag_mismatch("unexpected beat, pending", 1, 0);
			else begin
				want = pending_dates.pop_front();
				if (got.t.year !== want.t.year)
					flag_mismatch("out_year", got.t.year, want.t.year);
				if (got.t.month !== want.t.month)
					flag_mismatch("out_month", got.t.month, want.t.month);
				if (got.t.day !== want.t.day)
					flag_mismatch("out_day", got.t.day, want.t.day);
				if (got.t.hour !== want.t.hour)
					flag_mismatch("out_hour", got.t.hour, want.t.hour);
				if (got.t.minute !== want.t.minute)
					flag_mismatch("out_minute", got.t.minute, want.t.minute);
				if (got.bad !== want.bad)
					flag_mismatch("invalid", got.bad, want.bad);
			end
		end
	end

	initial begin
		csa_pkg::item_t it;
		outcome_t       want;
		int             drain_cycles;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats, under the first idling mix
		send_idle_pct = 30;
		recv_idle_pct = 74;
		for (int i = 0; i < N_DIR; i++) begin
			it.action = dir_rows[i].act;
			it.year   = csa_pkg::year_t'(dir_rows[i].y);
			it.month  = csa_pkg::month_t'(dir_rows[i].mo);
			it.day    = csa_pkg::day_t'(dir_rows[i].d);
			it.hour   = csa_pkg::hour_t'(dir_rows[i].h);
			it.minute = csa_pkg::min_t'(dir_rows[i].mi);
			if (dir_rows[i].typed) begin
				want.t.year   = csa_pkg::year_t'(dir_rows[i].ey);
				want.t.month  = csa_pkg::month_t'(dir_rows[i].emo);
				want.t.day    = csa_pkg::day_t'(dir_rows[i].ed);
				want.t.hour   = csa_pkg::hour_t'(dir_rows[i].eh);
				want.t.minute = csa_pkg::min_t'(dir_rows[i].emi);
				want.bad      = dir_rows[i].ebad;
			end else
				want = adjust_date(it);
			offer_date(it, want);
		end

		// random beats: slow receiver, then slow sender, then full rate
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					holds_asked++;  // full-rate sender against a long stall
				end
			endcase
			for (int n = 0; n < N_PER_PHASE; n++) begin
				it = make_date();
				offer_date(it, adjust_date(it));
			end
		end
		s_tvalid <= 1'b0;
		recv_idle_pct = 0;

		drain_cycles = 0;
		while (pending_dates.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_dates.size() != 0)
			flag_mismatch("beats never delivered", 0, pending_dates.size());

		if (fail_count == 0)
			$display("tb_calendar_step_adjust_core OK");
		else
			$display("tb_calendar_step_adjust_core NOT OK");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("tb_calendar_step_adjust_core NOT OK");
		$finish;
	end

endmodule
